@@ src/wws_pkg.sv @@
// shared types, constants and helper functions for the whole-word search core
package wws_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 16;

    localparam int LEN_W    = 6;
    localparam int WORD_W   = 64;
    localparam int OFFSET_W = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_WORD_0   = 3'd0,
        REG_PATTERN_WORD_1   = 3'd1,
        REG_PATTERN_WORD_2   = 3'd2,
        REG_PATTERN_WORD_3   = 3'd3,
        REG_PATTERN_LENGTH   = 3'd4,
        REG_SEPARATOR_LOW    = 3'd5,
        REG_SEPARATOR_HIGH   = 3'd6,
        REG_CASE_FOLD        = 3'd7
    } cfg_reg_t;

    // default separators: space , - _ tab . ? ! + : ; < > #
    localparam logic [WORD_W-1:0] SEP_LOW_RESET  = 64'hDC00_780B_0000_0200;
    localparam logic [WORD_W-1:0] SEP_HIGH_RESET = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [WORD_W-1:0] sep_low;
        logic [WORD_W-1:0] sep_high;
        logic              fold;
    } cfg_t;

    typedef struct packed {
        logic                emit;
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } step_result_t;

    // ascii upper case to lower case when folding is on
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b inside {[8'd65:8'd90]}))
            r = b + 8'd32;
        return r;
    endfunction

endpackage

@@ src/whole_word_search_core.sv @@
// top level of the streaming whole-word search core
//
//  channel  direction  signals                          contents
//  s_*      in         tvalid tready tdata[7:0] tlast   tdata: text_byte; tlast: last_byte
//  m_*      out        tvalid tready tdata[15:0] tuser  tdata: start_offset; tuser: found
//  cfg_*    in         write index[2:0] data[63:0]      register writes, no read-back
//
//  one text byte per cycle unless a held result stalls it, set by the combinational
//  step between the input register and the result register; a result is loaded into
//  the result register as its byte moves straight on from the input register
//  rst_n clears the match state, the valid flags and the configuration registers to defaults
//  a held result stalls the input register only when the next byte also emits
module whole_word_search_core
    import wws_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // text stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] text_byte
    input  logic                  s_tlast,    // last_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OFFSET_W-1:0]   m_tdata,    // [15:0] start_offset
    output logic [0:0]            m_tuser,    // [0] found
    // configuration
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    logic [MAX_PATTERN*8-1:0] pattern;
    cfg_t                     cfg;
    step_result_t             result;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    logic consume;

    wws_cfg_regs #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern),
        .cfg       (cfg)
    );

    wws_matcher #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .pattern   (pattern),
        .cfg       (cfg),
        .step      (consume),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    // the held byte moves on unless it emits and the result slot stays full
    assign consume  = in_valid_reg && (!result.emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // text payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (consume && result.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload, loaded when a step emits
    always_ff @(posedge clk)
    begin
        if (consume && result.emit)
        begin
            out_found_reg  <= result.found;
            out_offset_reg <= result.offset;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_offset_reg;
    assign m_tuser[0] = out_found_reg;

endmodule

@@ src/wws_cfg_regs.sv @@
// configuration register file: pattern bytes, length, separator mask and case fold
module wws_cfg_regs
    import wws_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [WORD_W-1:0]          cfg_data,
    output logic [MAX_PATTERN*8-1:0]   pattern,
    output cfg_t                       cfg
);

    logic [MAX_PATTERN*8-1:0] pattern_reg;
    cfg_t                     cfg_reg;

    // only the bytes that a usable length can reach are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else if (cfg_write)
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_PATTERN_WORD_0 + (j >> 3)))
                    pattern_reg[j*8 +: 8] <= cfg_data[(j & 7)*8 +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length   <= '0;
            cfg_reg.sep_low  <= SEP_LOW_RESET;
            cfg_reg.sep_high <= SEP_HIGH_RESET;
            cfg_reg.fold     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: cfg_reg.length   <= cfg_data[LEN_W-1:0];
                REG_SEPARATOR_LOW:  cfg_reg.sep_low  <= cfg_data;
                REG_SEPARATOR_HIGH: cfg_reg.sep_high <= cfg_data;
                REG_CASE_FOLD:      cfg_reg.fold     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign pattern = pattern_reg;
    assign cfg     = cfg_reg;

endmodule

@@ src/wws_matcher.sv @@
// per-text match state and the combinational step for one text byte
module wws_matcher
    import wws_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [MAX_PATTERN*8-1:0] pattern,
    input  cfg_t                     cfg,
    input  logic                     step,
    input  logic [7:0]               text_byte,
    input  logic                     last_byte,
    output step_result_t             result
);

    localparam int IDX_W = $clog2(MAX_PATTERN + 1);
    localparam int END_W = POSITION_BITS + 1;

    logic [IDX_W-1:0]         idx_reg,   idx_next;
    logic                     in_match_reg, in_match_next;
    logic                     after_sep_reg, after_sep_next;
    logic                     given_reg, given_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;

    logic [7:0]       b;
    logic [7:0]       pat_byte;
    logic             sep;
    logic             usable;
    logic             complete;
    logic             hit;
    logic             found_last;
    logic [END_W-1:0] end_pos;
    logic [END_W-1:0] diff;

    assign b = fold_byte(text_byte, cfg.fold);

    // separator lookup, codes above 127 never separate
    always_comb
    begin
        if (b[7])
            sep = 1'b0;
        else if (b[6])
            sep = cfg.sep_high[b[5:0]];
        else
            sep = cfg.sep_low[b[5:0]];
    end

    always_comb
    begin
        pat_byte = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (idx_reg == IDX_W'(i))
                pat_byte = pattern[i*8 +: 8];
        end
        pat_byte = fold_byte(pat_byte, cfg.fold);
    end

    assign usable   = (cfg.length != '0) && (cfg.length <= LEN_W'(MAX_PATTERN));
    assign complete = LEN_W'(idx_reg) >= cfg.length;

    always_comb
    begin
        idx_next       = idx_reg;
        in_match_next  = in_match_reg;
        after_sep_next = after_sep_reg;
        given_next     = given_reg;
        pos_next       = pos_reg;
        hit            = 1'b0;

        if (!given_reg)
        begin
            if (in_match_reg)
            begin
                if (complete)
                begin
                    // word ended: a match only if a separator closes it
                    hit            = sep;
                    given_next     = sep;
                    in_match_next  = 1'b0;
                    idx_next       = '0;
                    after_sep_next = 1'b0;
                end
                else if (b == pat_byte)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    in_match_next  = 1'b0;
                    idx_next       = '0;
                    after_sep_next = sep;
                end
            end
            else if (!after_sep_reg)
            begin
                if (sep)
                    after_sep_next = 1'b1;
            end
            else if (usable && (b == pat_byte))
            begin
                in_match_next = 1'b1;
                idx_next      = IDX_W'(1);
            end
            else
            begin
                after_sep_next = sep;
            end
        end

        found_last = in_match_next && (LEN_W'(idx_next) >= cfg.length);

        if (last_byte)
        begin
            idx_next       = '0;
            in_match_next  = 1'b0;
            after_sep_next = 1'b1;
            given_next     = 1'b0;
            pos_next       = '0;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // start offset: end position less the length, clamped at zero and saturated
    assign end_pos = hit ? END_W'(pos_reg) : (END_W'(pos_reg) + END_W'(1));
    assign diff    = (end_pos >= END_W'(cfg.length)) ? (end_pos - END_W'(cfg.length)) : '0;

    always_comb
    begin
        result.emit   = hit || (last_byte && !given_reg);
        result.found  = hit || (last_byte && !given_reg && found_last);
        result.offset = '0;
        if (result.found)
        begin
            if (diff > END_W'(17'h0FFFF))
                result.offset = '1;
            else
                result.offset = OFFSET_W'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            in_match_reg  <= 1'b0;
            after_sep_reg <= 1'b1;
            given_reg     <= 1'b0;
            pos_reg       <= '0;
        end
        else if (step)
        begin
            idx_reg       <= idx_next;
            in_match_reg  <= in_match_next;
            after_sep_reg <= after_sep_next;
            given_reg     <= given_next;
            pos_reg       <= pos_next;
        end
    end

endmodule
